[rtl/rwpm_pkg.sv]
`timescale 1ns / 1ps

package rwpm_pkg;

  // Default ring capacity
  localparam int RWPM_MAX_N = 1024;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 11;
  localparam int BEST_W  = 33;

  // Deque key v(p)-p: a 32-bit value minus a position of PW bits
  localparam int KEY_W  = 33;
  // Pair sum v(i) + i + key before truncation to the result width
  localparam int CAND_W = KEY_W + 2;

  // Ring length after reset, and the smallest usable length
  localparam logic [LEN_W-1:0] RING_LEN_RST = LEN_W'(2);
  localparam logic [LEN_W-1:0] RING_LEN_MIN = LEN_W'(2);

  // Per-step control broadcast to every deque cell
  typedef struct packed {
    logic clear;  // empty the deque before a walk
    logic step;   // one walk step: optional pop, then push
    logic pop;    // head entry has left the window
  } rwpm_ctl_t;

endpackage

[rtl/rwpm_if.sv]
`timescale 1ns / 1ps

// Input channel: one ring value per transaction
interface rwpm_in_if;
  import rwpm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one best pair sum per completed load
interface rwpm_out_if;
  import rwpm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best;
  modport source (output valid, output best, input ready);
  modport sink   (input valid, input best, output ready);
endinterface

// Configuration channel: ring length write
interface rwpm_cfg_if;
  import rwpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] ring_len;
  modport source (output valid, output ring_len, input ready);
  modport sink   (input valid, input ring_len, output ready);
endinterface

[rtl/rwpm_ram.sv]
`timescale 1ns / 1ps

module rwpm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rwpm_cell.sv]
`timescale 1ns / 1ps

module rwpm_cell
  import rwpm_pkg::*;
#(
  parameter int PW = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rwpm_ctl_t               ctl,
  input  logic [PW-1:0]           new_pos,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic                    left_cond,
  input  logic                    nb_vld,
  input  logic [PW-1:0]           nb_pos,
  input  logic signed [KEY_W-1:0] nb_key,
  output logic                    cond,
  output logic                    vld,
  output logic [PW-1:0]           pos,
  output logic signed [KEY_W-1:0] key
);

  logic                    vld_r;
  logic [PW-1:0]           pos_r;
  logic signed [KEY_W-1:0] key_r;

  logic                    e_vld;
  logic [PW-1:0]           e_pos;
  logic signed [KEY_W-1:0] e_key;

  // Entry after the head pop: take the neighbor toward the tail
  always_comb begin
    if (ctl.pop) begin
      e_vld = nb_vld;
      e_pos = nb_pos;
      e_key = nb_key;
    end else begin
      e_vld = vld_r;
      e_pos = pos_r;
      e_key = key_r;
    end
  end

  // Entry is empty or dominated by the incoming key
  assign cond = !e_vld || (e_key < new_key);

  // First dominated cell takes the new key, later dominated cells drop, the rest keep their entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.step) begin
      if (cond && !left_cond) begin
        vld_r <= 1'b1;
        pos_r <= new_pos;
        key_r <= new_key;
      end else if (cond) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= e_vld;
        pos_r <= e_pos;
        key_r <= e_key;
      end
    end
  end

  assign vld = vld_r;
  assign pos = pos_r;
  assign key = key_r;

endmodule

[rtl/ring_window_pair_max.sv]
`timescale 1ns / 1ps

// Ring window pair maximum. Values arrive one per cycle into a value memory while
// input is ready; after n = ring_len values (clamped to 2..MAX_N) the block walks
// the ring twice, one position per cycle, keeping a monotonic deque of keys v(p)-p
// in a row of MAX_N/2+1 cells that shift toward the head on expiry and drop
// dominated entries on each push. The walk reads the value memory, forms each pair
// sum in a compare register and keeps the best, which is presented once the walk
// has drained and the result register is free. A new load is not accepted until
// then. Input is held off during the walk and drain and while a length write is
// offered, and a length write is taken only in the load state.
// Writing ring_len discards a partly loaded ring.
module ring_window_pair_max
  import rwpm_pkg::*;
#(
  parameter int MAX_N = RWPM_MAX_N
) (
  input  logic       clk,
  input  logic       rst_n,
  rwpm_in_if.sink    in_ch,
  rwpm_out_if.source out_ch,
  rwpm_cfg_if.sink   cfg_ch
);

  localparam int AW    = $clog2(MAX_N);
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int PW    = $clog2(2 * MAX_N + 1);
  localparam int NCELL = MAX_N / 2 + 1;

  typedef enum logic [1:0] {S_LOAD, S_WALK, S_DRAIN} state_t;

  state_t                   state_r;
  logic [LEN_W-1:0]         ring_len_r;
  logic [AW-1:0]            load_cnt_r;
  logic [PW-1:0]            rd_i_r;
  logic [AW-1:0]            rd_addr_r;
  logic                     s1_vld_r;
  logic [PW-1:0]            s1_i_r;
  logic                     cand_vld_r;
  logic signed [CAND_W-1:0] cand_r;
  logic [BEST_W-1:0]        best_r;
  logic                     out_vld_r;
  logic [BEST_W-1:0]        out_best_r;

  logic [NW-1:0]            n_eff;
  logic [NW-1:0]            half;
  logic [PW-1:0]            two_n;
  logic                     in_acc;
  logic                     cfg_acc;
  logic                     load_last;
  logic                     walk_start;
  logic                     out_load;
  logic [VALUE_W-1:0]       rdata;
  logic signed [VALUE_W-1:0] x;
  logic signed [KEY_W-1:0]  new_key;
  logic signed [KEY_W-1:0]  head_key;
  logic signed [CAND_W-1:0] cand_nxt;
  logic                     pop;
  rwpm_ctl_t                ctl;

  logic                     c_vld  [NCELL];
  logic [PW-1:0]            c_pos  [NCELL];
  logic signed [KEY_W-1:0]  c_key  [NCELL];
  logic                     c_cond [NCELL];

  // Clamp ring length into the supported range
  always_comb begin
    if (ring_len_r < RING_LEN_MIN) begin
      n_eff = NW'(2);
    end else if (32'(ring_len_r) > 32'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(ring_len_r);
    end
  end

  assign half  = n_eff >> 1;
  assign two_n = PW'({n_eff, 1'b0});

  // Handshakes: a length write takes the load slot ahead of a value
  assign in_ch.ready  = (state_r == S_LOAD) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_LOAD);
  assign out_ch.valid = out_vld_r;
  assign out_ch.best  = out_best_r;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign cfg_acc    = cfg_ch.valid && cfg_ch.ready;
  assign load_last  = (NW'(load_cnt_r) + NW'(1)) == n_eff;
  assign walk_start = in_acc && !cfg_acc && load_last;
  assign out_load   = (state_r == S_DRAIN) && !s1_vld_r && !cand_vld_r &&
                      (!out_vld_r || out_ch.ready);

  // Value store
  rwpm_ram #(
    .W     (VALUE_W),
    .DEPTH (MAX_N)
  ) u_value_ram (
    .clk   (clk),
    .we    (in_acc && !cfg_acc),
    .waddr (load_cnt_r),
    .wdata (in_ch.value),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  assign x = signed'(rdata);

  // Walk step: expire head, form pair sum from head key, push v(i)-i
  assign pop     = s1_vld_r && c_vld[0] &&
                   (({1'b0, c_pos[0]} + (PW+1)'(half)) < (PW+1)'(s1_i_r));
  assign new_key = signed'({{(KEY_W-VALUE_W){x[VALUE_W-1]}}, x}) -
                   signed'({{(KEY_W-PW){1'b0}}, s1_i_r});
  assign head_key = pop ? c_key[1] : c_key[0];
  assign cand_nxt = signed'({{(CAND_W-VALUE_W){x[VALUE_W-1]}}, x}) +
                    signed'({{(CAND_W-PW){1'b0}}, s1_i_r}) +
                    signed'({{(CAND_W-KEY_W){head_key[KEY_W-1]}}, head_key});

  assign ctl.clear = walk_start;
  assign ctl.step  = s1_vld_r;
  assign ctl.pop   = pop;

  // Deque cell row, head at cell 0
  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      logic                    l_cond;
      logic                    r_vld;
      logic [PW-1:0]           r_pos;
      logic signed [KEY_W-1:0] r_key;

      if (g == 0) begin : g_head
        assign l_cond = 1'b0;
      end else begin : g_body
        assign l_cond = c_cond[g-1];
      end

      if (g == NCELL - 1) begin : g_tail
        assign r_vld = 1'b0;
        assign r_pos = '0;
        assign r_key = '0;
      end else begin : g_link
        assign r_vld = c_vld[g+1];
        assign r_pos = c_pos[g+1];
        assign r_key = c_key[g+1];
      end

      rwpm_cell #(
        .PW (PW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_pos   (s1_i_r),
        .new_key   (new_key),
        .left_cond (l_cond),
        .nb_vld    (r_vld),
        .nb_pos    (r_pos),
        .nb_key    (r_key),
        .cond      (c_cond[g]),
        .vld       (c_vld[g]),
        .pos       (c_pos[g]),
        .key       (c_key[g])
      );
    end
  endgenerate

  // Sequencer, walk pipeline and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      ring_len_r <= RING_LEN_RST;
      load_cnt_r <= '0;
      rd_i_r     <= '0;
      rd_addr_r  <= '0;
      s1_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
      best_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if (out_load) begin
        out_vld_r  <= 1'b1;
        out_best_r <= best_r;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      // Advance the read and compare stages
      s1_vld_r   <= (state_r == S_WALK);
      s1_i_r     <= rd_i_r;
      cand_vld_r <= s1_vld_r && (s1_i_r >= PW'(2));
      cand_r     <= cand_nxt;
      if (cand_vld_r && (cand_r > signed'({{(CAND_W-BEST_W){1'b0}}, best_r}))) begin
        best_r <= cand_r[BEST_W-1:0];
      end

      unique case (state_r)
        S_LOAD: begin
          if (cfg_acc) begin
            ring_len_r <= cfg_ch.ring_len;
            load_cnt_r <= '0;
          end else if (in_acc) begin
            if (load_last) begin
              load_cnt_r <= '0;
              rd_i_r     <= PW'(1);
              rd_addr_r  <= '0;
              best_r     <= '0;
              state_r    <= S_WALK;
            end else begin
              load_cnt_r <= load_cnt_r + AW'(1);
            end
          end
        end
        S_WALK: begin
          rd_i_r <= rd_i_r + PW'(1);
          if (NW'(rd_addr_r) + NW'(1) == n_eff) begin
            rd_addr_r <= '0;
          end else begin
            rd_addr_r <= rd_addr_r + AW'(1);
          end
          if (rd_i_r == two_n) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule
